@@ design/dwt_pkg.sv @@
// Package for the death watch table: sizes, field codes, item and slot types.
// No dependencies; every other design file takes names from here by scope.
package dwt_pkg;

	localparam int WatchEntries = 32;
	localparam int PortIdBits   = 12;
	localparam int ResultLimit  = 32;
	localparam int IdxBits      = $clog2(WatchEntries);
	localparam int CntBits      = $clog2(ResultLimit + 1);

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_FIRE    = 2'd1;
	localparam logic [1:0] OP_CLEANUP = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_DEAD   = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_NOTIFY = 2'd3;

	typedef struct packed {
		logic [1:0]            operation;
		logic [15:0]           watcher_id;
		logic [PortIdBits-1:0] dest_port;
		logic [31:0]           notify_code;
		logic [PortIdBits-1:0] watch_port;
		logic [31:0]           watch_gen;
		logic [31:0]           live_gen;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [PortIdBits-1:0] out_notify_port;
		logic [31:0]           out_code;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic [15:0]           watcher;
		logic [PortIdBits-1:0] nport;
		logic [31:0]           code;
		logic [PortIdBits-1:0] tport;
		logic [31:0]           tgen;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

@@ design/dwt_req_if.sv @@
// Request channel of the death watch table: valid, ready and one input item.
// Depends on dwt_pkg for the item type.
interface dwt_req_if;
	logic             valid;
	logic             ready;
	dwt_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/dwt_rsp_if.sv @@
// Result channel of the death watch table: valid, ready and one result item.
// Depends on dwt_pkg for the item type.
interface dwt_rsp_if;
	logic               valid;
	logic               ready;
	dwt_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/death_watch_table_unit.sv @@
// Death watch table: one-shot watches on port incarnations, held in a slot memory.
// Depends on dwt_pkg, dwt_req_if and dwt_rsp_if.
//
// Usage:
//   req carries one request per transfer: add a watch, fire on a port death, or
//   clean up every watch of one watcher. rsp carries the results: one for add,
//   cleanup and an unused code, one per freed watch (or a single "no match")
//   for fire; last marks the final result of a request.
//   Flow: the idle state takes a request and reads the first slot; the scan
//   state then walks the slots one a cycle, unless a fire is held, through
//   the single read port of the slot memory (a registered read); then the
//   finish state posts the final result. An add refused as dead, or an
//   unused code, skips the walk; an add that finds a duplicate ends
//   its walk early. One request is in work at a time; the next is taken
//   while the previous final result still waits in the output register.
//   Reset clears all slot valid bits at once; the memory contents are left
//   undefined and never used for an unused slot. No clearing pass is needed.
//   A stalled receiver holds the output register; a fire that needs to post
//   another notification halts its walk until the register is free.
module death_watch_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	dwt_req_if.sink     req,
	dwt_rsp_if.source   rsp
);

	localparam int IB = dwt_pkg::IdxBits;
	localparam int CB = dwt_pkg::CntBits;
	localparam int PB = dwt_pkg::PortIdBits;

	// Slot memory: payload of every watch; valid bits live in flip-flops.
	dwt_pkg::slot_t slot_mem [dwt_pkg::WatchEntries];
	dwt_pkg::slot_t rd_q;

	logic [dwt_pkg::WatchEntries-1:0] used_q;

	dwt_pkg::state_t   state_q, state_d;
	dwt_pkg::in_item_t item_q;
	logic [IB-1:0]     idx_q;
	logic [CB-1:0]     cnt_q;
	logic              free_found_q;
	logic [IB-1:0]     free_idx_q;
	logic              dup_q;
	logic              pend_valid_q;
	logic [PB-1:0]     pend_port_q;
	logic [31:0]       pend_code_q;

	logic               out_valid_q;
	dwt_pkg::out_item_t out_q;

	// Control from the output block
	logic               rd_en;
	logic [IB-1:0]      rd_addr;
	logic               wr_en;
	logic               out_load;
	dwt_pkg::out_item_t out_d;
	logic               advance;
	logic               scan_end;
	logic               finish_done;

	// Compare of the entry just read against the held request
	logic used_here, dup_hit, fire_hit, wipe_hit, last_idx, out_free;
	logic in_dead, item_dead, in_skip;

	always_comb begin
		used_here = used_q[idx_q];
		dup_hit   = used_here && rd_q.nport == item_q.dest_port &&
		            rd_q.tport == item_q.watch_port && rd_q.tgen == item_q.watch_gen;
		fire_hit  = used_here && rd_q.tport == item_q.watch_port &&
		            rd_q.tgen == item_q.watch_gen &&
		            cnt_q < CB'(dwt_pkg::ResultLimit);
		wipe_hit  = used_here && rd_q.watcher == item_q.watcher_id;
		last_idx  = idx_q == IB'(dwt_pkg::WatchEntries - 1);
		out_free  = !out_valid_q || rsp.ready;
		in_dead   = req.data.watch_gen == 32'd0 || req.data.live_gen != req.data.watch_gen;
		item_dead = item_q.watch_gen == 32'd0 || item_q.live_gen != item_q.watch_gen;
		in_skip   = !(req.data.operation inside {dwt_pkg::OP_ADD, dwt_pkg::OP_FIRE,
		                                         dwt_pkg::OP_CLEANUP}) ||
		            (req.data.operation == dwt_pkg::OP_ADD && in_dead);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dwt_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = in_skip ? dwt_pkg::ST_FINISH : dwt_pkg::ST_SCAN;
				end
			end
			dwt_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = dwt_pkg::ST_FINISH;
				end
			end
			dwt_pkg::ST_FINISH: begin
				if (finish_done) begin
					state_d = dwt_pkg::ST_IDLE;
				end
			end
			default: state_d = dwt_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath control
	always_comb begin
		req.ready   = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		wr_en       = 1'b0;
		out_load    = 1'b0;
		out_d       = '0;
		advance     = 1'b0;
		scan_end    = 1'b0;
		finish_done = 1'b0;
		case (state_q)
			dwt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				rd_en     = req.valid;
				rd_addr   = '0;
			end
			dwt_pkg::ST_SCAN: begin
				// Hold the walk while an earlier notification cannot be posted
				advance = !(item_q.operation == dwt_pkg::OP_FIRE && fire_hit &&
				            pend_valid_q && !out_free);
				if (advance && item_q.operation == dwt_pkg::OP_FIRE && fire_hit &&
				    pend_valid_q) begin
					out_load              = 1'b1;
					out_d.status          = dwt_pkg::STAT_NOTIFY;
					out_d.out_notify_port = pend_port_q;
					out_d.out_code        = pend_code_q;
					out_d.last            = 1'b0;
				end
				scan_end = advance && (last_idx ||
				           (item_q.operation == dwt_pkg::OP_ADD && dup_hit) ||
				           (item_q.operation == dwt_pkg::OP_FIRE && fire_hit &&
				            cnt_q == CB'(dwt_pkg::ResultLimit - 1)));
				if (advance && !scan_end) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
				end
			end
			dwt_pkg::ST_FINISH: begin
				finish_done = out_free;
				out_load    = out_free;
				out_d.last  = 1'b1;
				case (item_q.operation)
					dwt_pkg::OP_ADD: begin
						if (item_dead) begin
							out_d.status = dwt_pkg::STAT_DEAD;
						end else if (dup_q) begin
							out_d.status = dwt_pkg::STAT_OK;
						end else if (free_found_q) begin
							out_d.status = dwt_pkg::STAT_OK;
							wr_en        = out_free;
						end else begin
							out_d.status = dwt_pkg::STAT_FULL;
						end
					end
					dwt_pkg::OP_FIRE: begin
						if (pend_valid_q) begin
							out_d.status          = dwt_pkg::STAT_NOTIFY;
							out_d.out_notify_port = pend_port_q;
							out_d.out_code        = pend_code_q;
						end
					end
					default: out_d.status = dwt_pkg::STAT_OK;
				endcase
			end
			default: ;
		endcase
	end

	// Slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[free_idx_q] <= '{watcher: item_q.watcher_id, nport: item_q.dest_port,
			                          code: item_q.notify_code, tport: item_q.watch_port,
			                          tgen: item_q.watch_gen};
		end
		if (rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	// Request payload needs no reset
	always_ff @(posedge clk) begin
		if (state_q == dwt_pkg::ST_IDLE && req.valid) begin
			item_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dwt_pkg::ST_IDLE;
			used_q       <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			dup_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_port_q  <= '0;
			pend_code_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dwt_pkg::ST_IDLE && req.valid) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				free_found_q <= 1'b0;
				dup_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (state_q == dwt_pkg::ST_SCAN && advance) begin
				idx_q <= idx_q + 1'b1;
				case (item_q.operation)
					dwt_pkg::OP_ADD: begin
						// Remember the lowest free slot; flag a duplicate
						if (!used_here && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						if (dup_hit) begin
							dup_q <= 1'b1;
						end
					end
					dwt_pkg::OP_FIRE: begin
						// Free the watch and hold its notification until the next match or the finish state
						if (fire_hit) begin
							used_q[idx_q] <= 1'b0;
							pend_valid_q  <= 1'b1;
							pend_port_q   <= rd_q.nport;
							pend_code_q   <= rd_q.code;
							cnt_q         <= cnt_q + 1'b1;
						end
					end
					dwt_pkg::OP_CLEANUP: begin
						if (wipe_hit) begin
							used_q[idx_q] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (wr_en) begin
				used_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// Output register parts the walk from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

@@ bench/dwt_result_check.sv @@
// Result checker for the death watch table: forecasts every result from the
// accepted requests and compares each accepted result with the oldest forecast.
// Depends on dwt_pkg and on the dwt_req_if and dwt_rsp_if channel interfaces.
module dwt_result_check (
	input  logic clk,
	input  logic arst_n,
	dwt_req_if   req,
	dwt_rsp_if   rsp,
	output int   mismatches,
	output int   backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import dwt_pkg::*;

	localparam int ReportLimit = 10;

	bit        watch_live [WatchEntries];
	slot_t     watch_slot [WatchEntries];
	out_item_t awaited_results [$];

	function automatic out_item_t outcome(input logic [1:0] status,
		input logic [PortIdBits-1:0] nport, input logic [31:0] code, input logic last);
		out_item_t r;
		r.status          = status;
		r.out_notify_port = nport;
		r.out_code        = code;
		r.last            = last;
		return r;
	endfunction

	function automatic logic [1:0] add_watch(input in_item_t it);
		int free_idx = -1;
		if (it.watch_gen == '0 || it.live_gen != it.watch_gen)
			return STAT_DEAD;
		for (int i = 0; i < WatchEntries; i++) begin
			if (!watch_live[i]) begin
				if (free_idx < 0)
					free_idx = i;
			end else if (watch_slot[i].nport == it.dest_port &&
				watch_slot[i].tport == it.watch_port && watch_slot[i].tgen == it.watch_gen) begin
				return STAT_OK;
			end
		end
		if (free_idx < 0)
			return STAT_FULL;
		watch_live[free_idx]       = 1'b1;
		watch_slot[free_idx].watcher = it.watcher_id;
		watch_slot[free_idx].nport   = it.dest_port;
		watch_slot[free_idx].code    = it.notify_code;
		watch_slot[free_idx].tport   = it.watch_port;
		watch_slot[free_idx].tgen    = it.watch_gen;
		return STAT_OK;
	endfunction

	// Update the watch table for one request and queue the results it causes.
	function automatic void apply_request(input in_item_t it);
		int        fired = 0;
		out_item_t tail;
		case (it.operation)
			OP_ADD: awaited_results.push_back(outcome(add_watch(it), '0, '0, 1'b1));
			OP_FIRE: begin
				for (int i = 0; i < WatchEntries && fired < ResultLimit; i++) begin
					if (watch_live[i] && watch_slot[i].tport == it.watch_port &&
						watch_slot[i].tgen == it.watch_gen) begin
						awaited_results.push_back(outcome(STAT_NOTIFY, watch_slot[i].nport,
							watch_slot[i].code, 1'b0));
						watch_live[i] = 1'b0;
						fired++;
					end
				end
				if (fired == 0) begin
					awaited_results.push_back(outcome(STAT_OK, '0, '0, 1'b1));
				end else begin
					tail = awaited_results.pop_back();
					tail.last = 1'b1;
					awaited_results.push_back(tail);
				end
			end
			OP_CLEANUP: begin
				for (int i = 0; i < WatchEntries; i++)
					if (watch_live[i] && watch_slot[i].watcher == it.watcher_id)
						watch_live[i] = 1'b0;
				awaited_results.push_back(outcome(STAT_OK, '0, '0, 1'b1));
			end
			default: awaited_results.push_back(outcome(STAT_OK, '0, '0, 1'b1));
		endcase
	endfunction

	function automatic void check_result(input out_item_t got);
		out_item_t want;
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= ReportLimit)
				$display("%0t: unexpected result: status %0d port %0h code %0h last %0b",
					$time, got.status, got.out_notify_port, got.out_code, got.last);
			return;
		end
		want = awaited_results.pop_front();
		if (got.status !== want.status || got.out_notify_port !== want.out_notify_port ||
			got.out_code !== want.out_code || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= ReportLimit)
				$display({"%0t: result mismatch: expected status %0d port %0h code %0h ",
					"last %0b, got status %0d port %0h code %0h last %0b"},
					$time, want.status, want.out_notify_port, want.out_code, want.last,
					got.status, got.out_notify_port, got.out_code, got.last);
		end
	endfunction

	// Retire the result first: a result taken on this edge never belongs to a
	// request taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (watch_live[i])
				watch_live[i] = 1'b0;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result(rsp.data);
			if (req.valid && req.ready)
				apply_request(req.data);
		end
		backlog = awaited_results.size();
	end

endmodule

@@ bench/tb.sv @@
// Top of the death watch table testbench: clock, reset, request stimulus and
// result back-pressure; the verdict comes from the count of dwt_result_check.
// Depends on dwt_pkg, dwt_req_if, dwt_rsp_if, death_watch_table_unit, dwt_result_check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dwt_pkg::*;

	// operation code with no meaning: the block must answer it with a plain OK
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int CycleLimit  = 200000;
	localparam int HoldCycles  = 300;
	localparam int DrainCycles = WatchEntries + 8;
	localparam int PoolSize    = 4;
	localparam int WatcherPool = 3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dwt_req_if req ();
	dwt_rsp_if rsp ();

	int fail_count;
	int outstanding;

	int unsigned cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit holdoff_go  = 1'b0;
	bit rx_hold     = 1'b0;

	// Small pools of ports, incarnations, watchers and notify ports, so that
	// random adds collide, duplicate and later fire instead of scattering.
	logic [PortIdBits-1:0] pool_port   [PoolSize];
	logic [31:0]           pool_gen    [PoolSize];
	logic [PortIdBits-1:0] pool_notify [PoolSize];
	logic [15:0]           pool_watcher[WatcherPool];

	death_watch_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	dwt_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (fail_count),
		.backlog    (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung block: the slowest correct run is far shorter than this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Result side: hold ready low while a long hold-off runs, otherwise drop it
	// at random according to the current phase.
	always @(negedge clk) begin
		if (rx_hold)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Long receiver hold-off: count the stretch here while the sender keeps
	// offering, so the output register fills and the block stalls its input.
	initial begin : receiver_holdoff
		wait (holdoff_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCycles) @(negedge clk);
		rx_hold <= 1'b0;
	end

	function automatic in_item_t compose_request(input logic [1:0] op,
		input logic [15:0] watcher, input logic [PortIdBits-1:0] nport,
		input logic [31:0] code, input logic [PortIdBits-1:0] tport,
		input logic [31:0] tgen, input logic [31:0] live);
		in_item_t it;
		it.operation   = op;
		it.watcher_id  = watcher;
		it.dest_port   = nport;
		it.notify_code = code;
		it.watch_port  = tport;
		it.watch_gen   = tgen;
		it.live_gen    = live;
		return it;
	endfunction

	function automatic logic [31:0] fresh_gen();
		logic [31:0] g = $urandom;
		return (g == '0) ? 32'd1 : g;
	endfunction

	// Offer one request from a falling edge; idle first at the sender's rate,
	// then hold valid until the transfer, and return on the next falling edge.
	task automatic offer(input in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= it;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
	endtask

	// Mostly well-formed traffic on the pools, with some stale snapshots,
	// reincarnations and a tail of pure noise that exercises every field bit.
	task automatic send_random(input int count);
		int          roll;
		int          p;
		logic [31:0] live;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			p    = $urandom_range(PoolSize - 1);
			// now and then a pooled port dies and comes back as a new incarnation
			if ($urandom_range(19) == 0)
				pool_gen[p] = fresh_gen();
			if (roll < 45) begin
				case ($urandom_range(9))
					0:       live = '0;
					1:       live = $urandom;
					default: live = pool_gen[p];
				endcase
				offer(compose_request(OP_ADD, pool_watcher[$urandom_range(WatcherPool - 1)],
					pool_notify[$urandom_range(PoolSize - 1)], $urandom, pool_port[p],
					pool_gen[p], live));
			end else if (roll < 75) begin
				offer(compose_request(OP_FIRE, 16'($urandom), PortIdBits'($urandom),
					$urandom, pool_port[p],
					($urandom_range(7) == 0) ? $urandom : pool_gen[p], $urandom));
			end else if (roll < 85) begin
				offer(compose_request(OP_CLEANUP, ($urandom_range(4) == 0) ? 16'($urandom) :
					pool_watcher[$urandom_range(WatcherPool - 1)], PortIdBits'($urandom),
					$urandom, PortIdBits'($urandom), $urandom, $urandom));
			end else begin
				offer(compose_request(2'($urandom_range(3)), 16'($urandom),
					PortIdBits'($urandom), $urandom, PortIdBits'($urandom), $urandom,
					$urandom));
			end
		end
	endtask

	initial begin : stimulus
		logic [PortIdBits-1:0] burst_port;
		logic [31:0]           burst_gen;

		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PoolSize; i++) begin
			pool_port[i]   = PortIdBits'($urandom);
			pool_gen[i]    = fresh_gen();
			pool_notify[i] = PortIdBits'($urandom);
		end
		for (int i = 0; i < WatcherPool; i++)
			pool_watcher[i] = 16'($urandom);

		// Phase one: sender rarely idle, receiver idle about half the time.
		tx_idle_pct = 13;
		rx_idle_pct = 48;

		// a fire on the empty table finds nothing
		offer(compose_request(OP_FIRE, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h0, 32'h0));
		// add refused as dead: no snapshot taken
		offer(compose_request(OP_ADD, 16'h1234, 12'h001, 32'h5, 12'h010, 32'h0, 32'h0));
		// add refused as dead: snapshot older than the live incarnation
		offer(compose_request(OP_ADD, 16'h1234, 12'h001, 32'h5, 12'h010, 32'h7, 32'h8));
		// add refused as dead: target port already closed
		offer(compose_request(OP_ADD, 16'h1234, 12'h001, 32'h5, 12'h010, 32'h7, 32'h0));
		// all-ones watch
		offer(compose_request(OP_ADD, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// same notify port, target and generation under another watcher: no-op
		offer(compose_request(OP_ADD, 16'h0000, 12'hFFF, 32'h0, 12'hFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// all-zero watch on generation one
		offer(compose_request(OP_ADD, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h1, 32'h1));
		// second watch on that target, other notify port
		offer(compose_request(OP_ADD, 16'hA5A5, 12'h5A5, 32'hDEAD_BEEF, 12'h000,
			32'h1, 32'h1));
		// unused operation code
		offer(compose_request(OP_UNUSED, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// fire on the right port, wrong incarnation
		offer(compose_request(OP_FIRE, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h2, 32'h0));
		// fire with two matches: both notifications, in slot order
		offer(compose_request(OP_FIRE, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h1, 32'h0));
		// the watches are one-shot: a repeated fire finds nothing
		offer(compose_request(OP_FIRE, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h1, 32'h0));
		// cleanup frees the all-ones watch, so its fire finds nothing
		offer(compose_request(OP_CLEANUP, 16'hFFFF, 12'h000, 32'h0, 12'h000, 32'h0, 32'h0));
		offer(compose_request(OP_FIRE, 16'h0000, 12'h000, 32'h0, 12'hFFF,
			32'hFFFF_FFFF, 32'h0));
		// cleanup of a watcher with nothing registered
		offer(compose_request(OP_CLEANUP, 16'h0000, 12'h000, 32'h0, 12'h000, 32'h0, 32'h0));

		send_random(35);

		// Phase two: the other way round. Fill the table past full, then
		// empty the burst with a single fire that posts one result per burst watch.
		tx_idle_pct = 48;
		rx_idle_pct = 13;
		burst_port = PortIdBits'($urandom);
		burst_gen  = fresh_gen();
		for (int k = 0; k <= WatchEntries; k++)
			offer(compose_request(OP_ADD, pool_watcher[k % WatcherPool],
				burst_port + PortIdBits'(k), $urandom, burst_port, burst_gen, burst_gen));
		offer(compose_request(OP_FIRE, '0, '0, '0, burst_port, burst_gen, '0));
		send_random(10);

		// Phase three: no idling on either side, apart from one long hold-off
		// of the receiver while requests keep coming.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holdoff_go  = 1'b1;
		send_random(25);
		req.valid <= 1'b0;

		// Drain: wait for every forecast result, then a walk's worth of quiet
		// so that a stray extra result would still be caught.
		while (outstanding != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
